### rtl/lbpm_pkg.sv
package lbpm_pkg;

  localparam int FRAMES = 16;
  localparam int SLOT_W = $clog2(FRAMES);
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int RDR_W  = 8;
  localparam int PAGE_W = 32;
  localparam int LIM_W  = 5;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(16);
  localparam logic [RDR_W-1:0] RDR_MAX     = {RDR_W{1'b1}};

  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_LOADED    = 3'd1;
  localparam logic [2:0] ST_EVICTED   = 3'd2;
  localparam logic [2:0] ST_NOVICTIM  = 3'd3;
  localparam logic [2:0] ST_BUSY      = 3'd4;
  localparam logic [2:0] ST_UNFIXED   = 3'd5;
  localparam logic [2:0] ST_NOTCACHED = 3'd6;

  localparam logic CMD_FIX   = 1'b0;
  localparam logic CMD_UNFIX = 1'b1;

  typedef struct packed {
    logic             excl;
    logic [RDR_W-1:0] readers;
  } latch_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    latch_t            value;
  } latch_wr_t;

endpackage

### rtl/lbpm_ram.sv
module lbpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/lbpm_latch_file.sv
module lbpm_latch_file (
  input  logic                      clk,
  input  logic                      rst,
  input  lbpm_pkg::latch_wr_t       wr,
  input  logic [lbpm_pkg::SLOT_W-1:0] raddr,
  output lbpm_pkg::latch_t          rd
);

  // Per-frame latch state; reset releases every latch at once.
  lbpm_pkg::latch_t lat [lbpm_pkg::FRAMES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lbpm_pkg::FRAMES; i++) begin
        lat[i] <= '0;
      end
    end else if (wr.en) begin
      lat[wr.slot] <= wr.value;
    end
  end

  assign rd = lat[raddr];

endmodule

### rtl/lru_buffer_pool_latch_manager_core.sv
// Sequence: busy stays high for the page scan, then on unfix or eviction for the LRU
// scan and the shift to the most recently used end. The memory walks read one entry
// per cycle. done is a one-cycle strobe in the cycle in which busy falls, and a new
// request is taken only once the block is idle again. The receiver cannot stall.
// Reset (rst, synchronous): all latches released, no frames in use, limit 16.
module lru_buffer_pool_latch_manager_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [31:0] page_id,
  input  logic        want_exclusive,
  input  logic        is_dirty,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  output logic        done,
  output logic [2:0]  status,
  output logic [3:0]  frame_slot,
  output logic        write_back,
  output logic [31:0] write_page
);

  localparam int SW = lbpm_pkg::SLOT_W;
  localparam int CW = lbpm_pkg::CNT_W;
  localparam int PW = lbpm_pkg::PAGE_W;

  // The sequencer walks three phases. The page scan reads the page memory
  // slot by slot; since occupied slots are exactly 0..used-1 and a page is
  // held at most once, this finds the same frame as a walk in LRU order. The
  // LRU scan then finds either the hit frame's position (unfix) or the first
  // unlatched frame (eviction). The shift phase moves that entry to the most
  // recently used end, reading position p+1 and writing position p in the next
  // cycle, so the write always trails the reads and never collides.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PSCAN = 4'b0010,
    S_LSCAN = 4'b0100,
    S_SHIFT = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0] iss, iss_next;
  logic          rd_pend, rd_pend_next;
  logic [SW-1:0] rd_idx, rd_idx_next;
  logic [SW-1:0] sel, sel_next;
  logic          victim_mode, victim_mode_next;
  logic          old_pend, old_pend_next;
  logic [PW-1:0] old_page, old_page_next;
  logic [CW-1:0] used, used_next;
  logic [4:0]    frame_limit;

  logic          cmd_q, excl_q, dirty_q;
  logic [PW-1:0] page_q;

  logic          emit;
  logic [2:0]    e_status;
  logic [SW-1:0] e_slot;
  logic          e_wb;
  logic [PW-1:0] e_page;

  logic          pg_we;
  logic [SW-1:0] pg_waddr, pg_raddr;
  logic [PW-1:0] pg_wdata, pg_rdata;
  logic          lru_we;
  logic [SW-1:0] lru_waddr, lru_raddr, lru_wdata, lru_rdata;

  lbpm_pkg::latch_wr_t lat_wr;
  logic [SW-1:0]       lat_raddr;
  lbpm_pkg::latch_t    lat_rd;

  logic room;
  logic pg_match, lscan_hit;

  lbpm_ram #(.WIDTH(PW), .DEPTH(lbpm_pkg::FRAMES)) u_page_ram (
    .clk(clk), .we(pg_we), .waddr(pg_waddr), .wdata(pg_wdata),
    .raddr(pg_raddr), .rdata(pg_rdata)
  );

  lbpm_ram #(.WIDTH(SW), .DEPTH(lbpm_pkg::FRAMES)) u_lru_ram (
    .clk(clk), .we(lru_we), .waddr(lru_waddr), .wdata(lru_wdata),
    .raddr(lru_raddr), .rdata(lru_rdata)
  );

  lbpm_latch_file u_latch (
    .clk(clk), .rst(rst), .wr(lat_wr), .raddr(lat_raddr), .rd(lat_rd)
  );

  assign busy = (state != S_IDLE);

  // A limit above the pool size acts as the pool size.
  assign room = (int'(used) < int'(frame_limit)) && (int'(used) < lbpm_pkg::FRAMES);

  assign pg_match  = rd_pend && (pg_rdata == page_q);
  assign lscan_hit = rd_pend && (victim_mode ?
                     (!lat_rd.excl && (lat_rd.readers == '0)) : (lru_rdata == sel));

  always_comb begin
    state_next       = state;
    iss_next         = iss;
    rd_pend_next     = 1'b0;
    rd_idx_next      = rd_idx;
    sel_next         = sel;
    victim_mode_next = victim_mode;
    old_pend_next    = old_pend;
    old_page_next    = old_page;
    used_next        = used;

    emit     = 1'b0;
    e_status = lbpm_pkg::ST_HIT;
    e_slot   = '0;
    e_wb     = 1'b0;
    e_page   = '0;

    pg_we     = 1'b0;
    pg_waddr  = sel;
    pg_wdata  = page_q;
    pg_raddr  = rd_idx;
    lru_we    = 1'b0;
    lru_waddr = rd_idx;
    lru_wdata = lru_rdata;
    lru_raddr = rd_idx;
    lat_wr    = '0;
    lat_raddr = sel;

    case (state)
      S_IDLE: begin
        if (start) begin
          iss_next      = '0;
          old_pend_next = 1'b0;
          state_next    = S_PSCAN;
        end
      end

      S_PSCAN: begin
        lat_raddr = rd_idx;
        if (pg_match || (!rd_pend && (iss == used))) begin
          if (cmd_q == lbpm_pkg::CMD_UNFIX) begin
            if (!pg_match) begin
              emit       = 1'b1;
              e_status   = lbpm_pkg::ST_NOTCACHED;
              state_next = S_IDLE;
            end else begin
              sel_next         = rd_idx;
              victim_mode_next = 1'b0;
              iss_next         = '0;
              state_next       = S_LSCAN;
            end
          end else if (pg_match) begin
            // Fix hit: latch if compatible, LRU order untouched.
            state_next = S_IDLE;
            emit       = 1'b1;
            if (excl_q ? (lat_rd.excl || (lat_rd.readers != '0))
                       : (lat_rd.excl || (lat_rd.readers == lbpm_pkg::RDR_MAX))) begin
              e_status = lbpm_pkg::ST_BUSY;
            end else begin
              e_status     = lbpm_pkg::ST_HIT;
              e_slot       = rd_idx;
              lat_wr.en    = 1'b1;
              lat_wr.slot  = rd_idx;
              lat_wr.value = lat_rd;
              if (excl_q) begin
                lat_wr.value.excl = 1'b1;
              end else begin
                lat_wr.value.readers = lat_rd.readers + 1'b1;
              end
            end
          end else if (room) begin
            // Miss with a free slot: the new slot goes to the MRU end.
            pg_we              = 1'b1;
            pg_waddr           = used[SW-1:0];
            lru_we             = 1'b1;
            lru_waddr          = used[SW-1:0];
            lru_wdata          = used[SW-1:0];
            lat_wr.en          = 1'b1;
            lat_wr.slot        = used[SW-1:0];
            lat_wr.value.excl  = excl_q;
            lat_wr.value.readers = excl_q ? '0 : lbpm_pkg::RDR_W'(1);
            used_next          = used + 1'b1;
            emit               = 1'b1;
            e_status           = lbpm_pkg::ST_LOADED;
            e_slot             = used[SW-1:0];
            state_next         = S_IDLE;
          end else begin
            victim_mode_next = 1'b1;
            iss_next         = '0;
            state_next       = S_LSCAN;
          end
        end else if (iss < used) begin
          pg_raddr     = iss[SW-1:0];
          rd_pend_next = 1'b1;
          rd_idx_next  = iss[SW-1:0];
          iss_next     = iss + 1'b1;
        end
      end

      S_LSCAN: begin
        lat_raddr = lru_rdata;
        if (lscan_hit) begin
          sel_next   = lru_rdata;
          iss_next   = CW'(rd_idx) + 1'b1;
          state_next = S_SHIFT;
          if (victim_mode) begin
            // Fetch the victim's page for the write-back report.
            pg_raddr      = lru_rdata;
            old_pend_next = 1'b1;
          end
        end else if (!rd_pend && (iss == used)) begin
          emit       = 1'b1;
          e_status   = lbpm_pkg::ST_NOVICTIM;
          state_next = S_IDLE;
        end else if (iss < used) begin
          lru_raddr    = iss[SW-1:0];
          rd_pend_next = 1'b1;
          rd_idx_next  = iss[SW-1:0];
          iss_next     = iss + 1'b1;
        end
      end

      S_SHIFT: begin
        if (old_pend) begin
          old_page_next = pg_rdata;
          old_pend_next = 1'b0;
        end
        if (rd_pend) begin
          lru_we    = 1'b1;
          lru_waddr = rd_idx - 1'b1;
          lru_wdata = lru_rdata;
        end
        if (iss < used) begin
          lru_raddr    = iss[SW-1:0];
          rd_pend_next = 1'b1;
          rd_idx_next  = iss[SW-1:0];
          iss_next     = iss + 1'b1;
        end else if (!rd_pend) begin
          lru_we     = 1'b1;
          lru_waddr  = SW'(used - 1'b1);
          lru_wdata  = sel;
          emit       = 1'b1;
          e_slot     = sel;
          state_next = S_IDLE;
          lat_wr.en   = 1'b1;
          lat_wr.slot = sel;
          if (cmd_q == lbpm_pkg::CMD_UNFIX) begin
            // An exclusive holder is released first, else one reader.
            lat_wr.value = lat_rd;
            if (lat_rd.excl) begin
              lat_wr.value.excl = 1'b0;
            end else if (lat_rd.readers != '0) begin
              lat_wr.value.readers = lat_rd.readers - 1'b1;
            end
            e_status = lbpm_pkg::ST_UNFIXED;
            e_wb     = dirty_q;
            e_page   = dirty_q ? page_q : '0;
          end else begin
            pg_we                = 1'b1;
            pg_waddr             = sel;
            lat_wr.value.excl    = excl_q;
            lat_wr.value.readers = excl_q ? '0 : lbpm_pkg::RDR_W'(1);
            e_status             = lbpm_pkg::ST_EVICTED;
            e_wb                 = 1'b1;
            e_page               = old_pend ? pg_rdata : old_page;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rd_pend     <= 1'b0;
      old_pend    <= 1'b0;
      used        <= '0;
      frame_limit <= lbpm_pkg::LIMIT_RESET;
      done        <= 1'b0;
    end else begin
      state    <= state_next;
      rd_pend  <= rd_pend_next;
      old_pend <= old_pend_next;
      used     <= used_next;
      done     <= emit;
      if (cfg_we) begin
        frame_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    iss         <= iss_next;
    rd_idx      <= rd_idx_next;
    sel         <= sel_next;
    victim_mode <= victim_mode_next;
    old_page    <= old_page_next;
    if ((state == S_IDLE) && start) begin
      cmd_q   <= command;
      page_q  <= page_id;
      excl_q  <= want_exclusive;
      dirty_q <= is_dirty;
    end
    if (emit) begin
      status     <= e_status;
      frame_slot <= 4'(e_slot);
      write_back <= e_wb;
      write_page <= e_page;
    end
  end

endmodule

### test/tb_lru_buffer_pool_latch_manager_core.sv
`timescale 1ns / 100ps

module tb_lru_buffer_pool_latch_manager_core;
  import lbpm_pkg::*;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #6 clk = ~clk;

  // Block inputs, all driven to known values from time zero.
  logic        start = 1'b0;
  logic        command = CMD_FIX;
  logic [31:0] page_id = '0;
  logic        want_exclusive = 1'b0;
  logic        is_dirty = 1'b0;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_data = '0;

  logic        busy;
  logic        done;
  logic [2:0]  status;
  logic [3:0]  frame_slot;
  logic        write_back;
  logic [31:0] write_page;

  lru_buffer_pool_latch_manager_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .page_id(page_id), .want_exclusive(want_exclusive),
    .is_dirty(is_dirty), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .done(done), .status(status), .frame_slot(frame_slot),
    .write_back(write_back), .write_page(write_page)
  );

  // One request and one answer.
  typedef struct {
    logic        cmd;
    logic [31:0] page;
    logic        excl;
    logic        dirty;
  } request_t;

  typedef struct {
    logic [2:0]  st;
    logic [3:0]  slot;
    logic        wb;
    logic [31:0] wpage;
  } answer_t;

  // Shadow copy of the pool. It mirrors the block and is advanced once for
  // every request that the block accepts.
  logic [PAGE_W-1:0] pool_page [FRAMES];
  logic [RDR_W-1:0]  pool_readers [FRAMES];
  logic              pool_excl [FRAMES];
  logic [SLOT_W-1:0] pool_lru [FRAMES];
  int                pool_used;
  logic [LIM_W-1:0]  pool_limit;

  answer_t pending_answers[$];
  int      errors = 0;
  int      cycles = 0;
  int      send_idle_pct = 0;
  // Pages that have been loaded at least once; random requests mostly use
  // these so that hits, latch conflicts and unfixes occur often.
  logic [31:0] known_pages[$];

  // The limit covers the slowest correct run: every request at the longest
  // scan plus the longest sender gap, taken several times over.
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 3 * FRAMES + 10;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL lru_buffer_pool_latch_manager_core");
      $finish;
    end
  end

  task automatic pool_clear();
    for (int i = 0; i < FRAMES; i++) begin
      pool_readers[i] = '0;
      pool_excl[i] = 1'b0;
      pool_lru[i] = '0;
      pool_page[i] = '0;
    end
    pool_used = 0;
    pool_limit = LIMIT_RESET;
  endtask

  // Moves the entry at LRU position pos to the most recently used end and
  // returns its slot.
  function automatic logic [SLOT_W-1:0] promote_to_mru(int pos);
    logic [SLOT_W-1:0] s;
    s = pool_lru[pos];
    for (int p = pos; p + 1 < pool_used; p++) pool_lru[p] = pool_lru[p + 1];
    if (pool_used > 0) pool_lru[pool_used - 1] = s;
    return s;
  endfunction

  // Works out the answer to one request and updates the shadow pool.
  function automatic answer_t pool_apply(request_t rq);
    answer_t a;
    int pos;
    int lim;
    logic [SLOT_W-1:0] s;
    a = '{st: ST_NOVICTIM, slot: '0, wb: 1'b0, wpage: '0};
    lim = (pool_limit > FRAMES) ? FRAMES : int'(pool_limit);
    pos = -1;
    for (int p = 0; p < pool_used; p++)
      if (pos < 0 && pool_page[pool_lru[p]] == rq.page) pos = p;

    if (rq.cmd == CMD_UNFIX) begin
      if (pos < 0) begin
        a.st = ST_NOTCACHED;
        return a;
      end
      s = promote_to_mru(pos);
      // An exclusive holder is released first, else one reader goes away.
      if (pool_excl[s]) pool_excl[s] = 1'b0;
      else if (pool_readers[s] != 0) pool_readers[s]--;
      a.st = ST_UNFIXED;
      a.slot = s;
      a.wb = rq.dirty;
      a.wpage = rq.dirty ? rq.page : '0;
      return a;
    end

    if (pos >= 0) begin
      // A hit latches the frame and leaves the LRU order alone.
      s = pool_lru[pos];
      if (rq.excl ? (pool_excl[s] || pool_readers[s] != 0)
                  : (pool_excl[s] || pool_readers[s] == RDR_MAX)) begin
        a.st = ST_BUSY;
        return a;
      end
      if (rq.excl) pool_excl[s] = 1'b1;
      else pool_readers[s]++;
      a.st = ST_HIT;
      a.slot = s;
      return a;
    end

    if (pool_used < lim) begin
      s = SLOT_W'(pool_used);
      pool_lru[pool_used] = s;
      pool_used++;
      pool_page[s] = rq.page;
      pool_excl[s] = rq.excl;
      pool_readers[s] = rq.excl ? '0 : RDR_W'(1);
      a.st = ST_LOADED;
      a.slot = s;
      return a;
    end

    // Evict the first unlatched frame in LRU order; its page is always
    // reported for write-back.
    for (int p = 0; p < pool_used; p++) begin
      s = pool_lru[p];
      if (!pool_excl[s] && pool_readers[s] == 0) begin
        a.st = ST_EVICTED;
        a.wb = 1'b1;
        a.wpage = pool_page[s];
        s = promote_to_mru(p);
        pool_page[s] = rq.page;
        pool_excl[s] = rq.excl;
        pool_readers[s] = rq.excl ? '0 : RDR_W'(1);
        a.slot = s;
        return a;
      end
    end
    return a;
  endfunction

  // Result checker: every strobe is one transfer and must match the oldest
  // pending answer field by field.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, status);
        errors++;
      end else begin
        answer_t e;
        e = pending_answers.pop_front();
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          errors++;
        end
        if (frame_slot !== e.slot) begin
          $display("%0t: frame_slot expected %0d actual %0d", $time, e.slot, frame_slot);
          errors++;
        end
        if (write_back !== e.wb) begin
          $display("%0t: write_back expected %0d actual %0d", $time, e.wb, write_back);
          errors++;
        end
        if (write_page !== e.wpage) begin
          $display("%0t: write_page expected %h actual %h", $time, e.wpage, write_page);
          errors++;
        end
      end
    end
  end

  // Sends one request. Start stays high from one request to the next unless
  // the sender idles; the block ignores it while busy. When there is a gap,
  // start drops first and rises again at a later edge. The request transfers
  // at the edge where start is high and busy is low. When a typed answer is
  // given it must also agree with the predictor, catching a slip in either.
  task automatic send_request(request_t rq, bit has_typed, answer_t typed);
    answer_t a;
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= rq.cmd;
    page_id <= rq.page;
    want_exclusive <= rq.excl;
    is_dirty <= rq.dirty;
    @(posedge clk);
    while (busy) @(posedge clk);
    a = pool_apply(rq);
    if (has_typed && (a.st !== typed.st || a.slot !== typed.slot ||
                      a.wb !== typed.wb || a.wpage !== typed.wpage)) begin
      $display("%0t: table expects status %0d but pool model gives %0d",
               $time, typed.st, a.st);
      errors++;
    end
    pending_answers = {pending_answers, a};
    if (rq.cmd == CMD_FIX && (a.st == ST_LOADED || a.st == ST_EVICTED))
      known_pages = {known_pages, rq.page};
  endtask

  // Lowers start, waits until every answer has arrived, then lets the block
  // settle.
  task automatic drain();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The limit register is only written while the block is idle.
  task automatic write_limit(logic [LIM_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_limit = v;
  endtask

  function automatic request_t random_request();
    request_t rq;
    rq.cmd = $urandom_range(99) < 45 ? CMD_UNFIX : CMD_FIX;
    rq.excl = $urandom_range(99) < 30;
    rq.dirty = 1'($urandom_range(1));
    case ($urandom_range(9))
      0: rq.page = $urandom();
      1: rq.page = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: begin
        if (known_pages.size() == 0) rq.page = $urandom_range(40);
        else rq.page = known_pages[$urandom_range(known_pages.size() - 1)];
      end
    endcase
    return rq;
  endfunction

  // Directed table; a typed answer is given only where it is plain.
  typedef struct {
    request_t rq;
    bit       has_typed;
    answer_t  typed;
  } table_row_t;

  localparam answer_t NOANS = '{st: '0, slot: '0, wb: 1'b0, wpage: '0};

  table_row_t directed_rows[$];

  task automatic add_row(logic c, logic [31:0] pg, logic x, logic d,
                         bit t, logic [2:0] st, logic [3:0] sl, logic wb,
                         logic [31:0] wp);
    table_row_t r;
    r.rq = '{cmd: c, page: pg, excl: x, dirty: d};
    r.has_typed = t;
    r.typed = '{st: st, slot: sl, wb: wb, wpage: wp};
    directed_rows = {directed_rows, r};
  endtask

  initial begin
    pool_clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with limit 2 so eviction starts at once.
    // Unfix of an unknown page answers not cached.
    add_row(CMD_UNFIX, 32'h0, 0, 1, 1, ST_NOTCACHED, 0, 0, 0);
    add_row(CMD_FIX, 32'h0, 1, 0, 1, ST_LOADED, 0, 0, 0);
    add_row(CMD_FIX, 32'hFFFF_FFFF, 0, 0, 1, ST_LOADED, 1, 0, 0);
    // Latch conflicts: a shared fix on an exclusive holder, an exclusive fix on a reader.
    add_row(CMD_FIX, 32'h0, 0, 0, 1, ST_BUSY, 0, 0, 0);
    add_row(CMD_FIX, 32'hFFFF_FFFF, 1, 0, 1, ST_BUSY, 0, 0, 0);
    add_row(CMD_FIX, 32'hFFFF_FFFF, 0, 0, 1, ST_HIT, 1, 0, 0);
    // Pool full, both frames latched: no victim.
    add_row(CMD_FIX, 32'h1234_5678, 0, 0, 1, ST_NOVICTIM, 0, 0, 0);
    add_row(CMD_UNFIX, 32'h0, 0, 1, 1, ST_UNFIXED, 0, 1, 32'h0);
    // Unfix of an unlatched frame still moves it and reports write-back.
    add_row(CMD_UNFIX, 32'h0, 0, 1, 1, ST_UNFIXED, 0, 1, 32'h0);
    add_row(CMD_FIX, 32'hA5A5_5A5A, 1, 0, 1, ST_EVICTED, 0, 1, 32'h0);
    add_row(CMD_UNFIX, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_UNFIX, 32'hFFFF_FFFF, 0, 1, 0, 0, 0, 0, 0);
    add_row(CMD_UNFIX, 32'hFFFF_FFFF, 0, 1, 0, 0, 0, 0, 0);
    add_row(CMD_FIX, 32'h5A5A_A5A5, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_UNFIX, 32'hA5A5_5A5A, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_FIX, 32'hA5A5_5A5A, 0, 0, 0, 0, 0, 0, 0);

    write_limit(LIM_W'(2));
    foreach (directed_rows[i])
      send_request(directed_rows[i].rq, directed_rows[i].has_typed,
                   directed_rows[i].typed);

    // Reader overflow: 255 shared fixes of one page, then one more.
    write_limit(LIM_W'(16));
    for (int i = 0; i < 256; i++)
      send_request('{cmd: CMD_FIX, page: 32'h0000_BEEF, excl: 1'b0, dirty: 1'b0},
                   i == 255, '{st: ST_BUSY, slot: '0, wb: 1'b0, wpage: '0});

    // Random phases through several limits, the extremes among them. The
    // first pair of phases idles the sender, the last ones do not.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_limit(LIM_W'(0));
        1: write_limit(LIM_W'(31));
        2: write_limit(LIM_W'(1));
        3: write_limit(LIM_W'(5));
        4: write_limit(LIM_W'(16));
        default: write_limit(LIM_W'($urandom_range(3, 12)));
      endcase
      send_idle_pct = (ph < 2) ? 8 : ((ph < 4) ? 81 : 0);
      for (int i = 0; i < 63; i++) begin
        send_request(random_request(), 0, NOANS);
      end
    end

    drain();
    if (errors == 0) begin
      $display("PASS lru_buffer_pool_latch_manager_core");
    end else begin
      $display("FAIL lru_buffer_pool_latch_manager_core");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lbpm_pkg.sv
rtl/lbpm_ram.sv
rtl/lbpm_latch_file.sv
rtl/lru_buffer_pool_latch_manager_core.sv
test/tb_lru_buffer_pool_latch_manager_core.sv
